### hw/rtl/utf8s_pkg.sv
// Package: shared types, constants and byte classification functions for the UTF-8 sanitizer.
package utf8s_pkg;

   localparam logic [7:0] QMARK      = 8'h3F;
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [1:0] pend_count_type;
   typedef logic [2:0] seq_len_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
      logic            last;
   } group_type;

   function automatic seq_len_type lead_length(input logic [7:0] b);
      seq_len_type len;
      case (b) inside
         [8'hC2:8'hDF]: len = 3'd2;
         [8'hE0:8'hEF]: len = 3'd3;
         [8'hF0:8'hF4]: len = 3'd4;
         default:       len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
      logic ok;
      case (lead)
         8'hE0:   ok = (b >= 8'hA0) && (b <= 8'hBF);
         8'hED:   ok = (b >= 8'h80) && (b <= 8'h9F);
         8'hF0:   ok = (b >= 8'h90) && (b <= 8'hBF);
         8'hF4:   ok = (b >= 8'h80) && (b <= 8'h8F);
         default: ok = (b[7:6] == 2'b10);
      endcase
      return ok;
   endfunction

endpackage

### hw/rtl/utf8s_ifs.sv
// Interfaces: request and response stream channels of the UTF-8 sanitizer.
interface utf8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface utf8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### hw/rtl/utf8s_front.sv
// Front end: accepts raw bytes, tracks the pending sequence and emits output groups.
module utf8s_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_is_last,
   input  logic                 q_full,
   output logic                 q_push,
   output utf8s_pkg::group_type q_group
);

   logic [2:0][7:0]           pend_ff, pend_in;
   utf8s_pkg::pend_count_type cnt_ff, cnt_in;
   utf8s_pkg::seq_len_type    seq_ff, seq_in;

   logic                      accept;
   logic                      ok;
   logic                      consumed;
   logic [2:0]                n;
   logic [3:0][7:0]           slots;
   utf8s_pkg::seq_len_type    len;
   logic [7:0]                b;

   assign b         = req_data_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      pend_in  = pend_ff;
      cnt_in   = cnt_ff;
      seq_in   = seq_ff;
      slots    = '0;
      n        = 3'd0;
      consumed = 1'b0;
      len      = utf8s_pkg::lead_length(b);
      ok       = (cnt_ff == 2'd1) ? utf8s_pkg::second_ok(pend_ff[0], b) : (b[7:6] == 2'b10);

      if (cnt_ff != 2'd0) begin
         if (ok) begin
            if (({1'b0, cnt_ff} + 3'd1) >= seq_ff) begin
               for (int i = 0; i < 3; i++) begin
                  if (3'(i) < {1'b0, cnt_ff}) slots[i] = pend_ff[i];
               end
               slots[cnt_ff] = b;
               n      = {1'b0, cnt_ff} + 3'd1;
               cnt_in = 2'd0;
               seq_in = 3'd0;
            end else begin
               pend_in[cnt_ff] = b;
               cnt_in          = cnt_ff + 2'd1;
            end
            consumed = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (3'(i) < {1'b0, cnt_ff}) slots[i] = utf8s_pkg::QMARK;
            end
            n      = {1'b0, cnt_ff};
            cnt_in = 2'd0;
            seq_in = 3'd0;
         end
      end

      if (!consumed) begin
         if (b[7] == 1'b0) begin
            slots[n[1:0]] = b;
            n             = n + 3'd1;
         end else if (len == 3'd0) begin
            slots[n[1:0]] = utf8s_pkg::QMARK;
            n             = n + 3'd1;
         end else begin
            pend_in[0] = b;
            cnt_in     = 2'd1;
            seq_in     = len;
         end
      end

      // end of string flushes whatever is still held
      if (req_is_last) begin
         for (int i = 0; i < 4; i++) begin
            if ((3'(i) >= n) && (3'(i) < (n + {1'b0, cnt_in}))) slots[i] = utf8s_pkg::QMARK;
         end
         n      = n + {1'b0, cnt_in};
         cnt_in = 2'd0;
         seq_in = 3'd0;
      end
   end

   assign q_push        = accept && (n != 3'd0);
   assign q_group.bytes = slots;
   assign q_group.count = n;
   assign q_group.last  = req_is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         seq_ff <= 3'd0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         seq_ff <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

### hw/rtl/utf8s_queue.sv
// Queue: short FIFO of output groups between front end and back end.
module utf8s_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  utf8s_pkg::group_type push_group,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output utf8s_pkg::group_type head_group
);

   utf8s_pkg::group_type                   entries_ff [utf8s_pkg::QUEUE_DEPTH];
   logic [utf8s_pkg::QPTR_W-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [utf8s_pkg::QPTR_W:0]             fill_ff, fill_in;
   logic                                   do_push, do_pop;

   assign full       = (fill_ff == (utf8s_pkg::QPTR_W+1)'(utf8s_pkg::QUEUE_DEPTH));
   assign not_empty  = (fill_ff != '0);
   assign head_group = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (do_pop && !do_push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

### hw/rtl/utf8s_back.sv
// Back end: serializes queued output groups into one response beat per cycle while rsp_ready is high.
module utf8s_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_not_empty,
   input  utf8s_pkg::group_type q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_out_last
);

   utf8s_pkg::group_type cur_ff;
   logic                 cur_valid_ff, cur_valid_in;
   logic [1:0]           idx_ff, idx_in;
   logic [1:0]           last_idx;
   logic                 beat;
   logic                 final_beat;
   logic                 load;

   assign last_idx   = 2'(cur_ff.count - 3'd1);
   assign beat       = cur_valid_ff && rsp_ready;
   assign final_beat = (idx_ff == last_idx);
   assign load       = !cur_valid_ff || (beat && final_beat);
   assign q_pop      = load && q_not_empty;

   assign rsp_valid    = cur_valid_ff;
   assign rsp_out_byte = cur_ff.bytes[idx_ff];
   assign rsp_out_last = cur_ff.last && final_beat;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_valid_in = q_not_empty;
         idx_in       = 2'd0;
      end else if (beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
   end

endmodule

### hw/rtl/utf8_sanitize_stream.sv
// Top level: UTF-8 stream sanitizer, front end, group queue and back end.
//
// req_bus carries raw string bytes (data_byte) with is_last on the final byte
// of each string. rsp_bus returns exactly as many bytes: well-formed UTF-8
// passes unchanged, every illegal byte becomes '?' (0x3F), out_last marks the
// final byte of each string.
// Bytes of an unfinished multi-byte sequence are held in the front end and
// released together once the sequence completes, fails or the string ends,
// so one request beat yields zero to four response beats.
// A byte that is released at once is written into the group queue and then into
// the back end's current-group register, from which rsp_bus presents it.
// Throughput: one request beat and one response beat per cycle while nothing stalls.
// req_bus.ready drops only while the four-entry group queue is full, which
// happens when the receiver stalls or when groups of several beats pile up.
// Reset (synchronous, active high) drops any held bytes and queued groups.
// A stalled response holds its payload until taken.
module utf8_sanitize_stream (
   input  logic             clock,
   input  logic             reset,
   utf8s_req_if.sink        req_bus,
   utf8s_rsp_if.source      rsp_bus
);

   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_not_empty;
   utf8s_pkg::group_type q_push_group;
   utf8s_pkg::group_type q_head;

   utf8s_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_data_byte (req_bus.data_byte),
      .req_is_last   (req_bus.is_last),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_group       (q_push_group)
   );

   utf8s_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_group (q_push_group),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head_group (q_head)
   );

   utf8s_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (q_not_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_out_byte (rsp_bus.out_byte),
      .rsp_out_last (rsp_bus.out_last)
   );

endmodule
